>>> hdl/sda_pkg.sv
// ============================================================================
// sda_pkg: shared constants, types and helpers of the signed decimal adder
// Holds the sizing constants, the controller-to-datapath command and status
// structs, and the digit clamp used on every operand word.
// ============================================================================
`default_nettype none

package sda_pkg;

   // Operand size in decimal digits and packing of digits into words.
   localparam int MAX_DIGITS      = 256;
   localparam int DIGITS_PER_WORD = 16;
   localparam int WORDS           = (MAX_DIGITS + DIGITS_PER_WORD - 1) / DIGITS_PER_WORD;

   // Field widths.
   localparam int WORD_W  = 64;
   localparam int COUNT_W = 9;

   // Index widths: operand stores, counters that reach WORDS, digit position.
   localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CNT_W   = $clog2(WORDS + 1);
   localparam int DIG_AW  = (DIGITS_PER_WORD > 1) ? $clog2(DIGITS_PER_WORD) : 1;

   // Decimal constants.
   localparam logic [3:0] DIGIT_MAX = 4'd9;
   localparam logic [4:0] RADIX     = 5'd10;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             store_wr;    // write the request words into the stores
      logic             cap_signs;   // capture both operand signs
      logic             clear_run;   // clear carry, compare and leading-digit state
      logic             op_rd;       // read both operand stores
      logic             cmp_eval;    // evaluate the word compare
      logic             arith_eval;  // compute one result word and store it
      logic             top_eval;    // store the final carry word
      logic             res_rd;      // read one result word for output
      logic [CNT_W-1:0] addr;        // word index for the command above
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic             signs_differ;  // operand signs differ: subtract
      logic             words_differ;  // compared operand words are not equal
      logic [CNT_W-1:0] last_idx;      // index of the last result word to send
   } status_type;

   // Forces every digit above nine down to nine and clears unused high bits.
   function automatic logic [WORD_W-1:0] clamp_word(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] r;
      logic [3:0]        nib;
      r = '0;
      for (int k = 0; k < DIGITS_PER_WORD; k++) begin
         nib = w[4*k +: 4];
         r[4*k +: 4] = (nib > DIGIT_MAX) ? DIGIT_MAX : nib;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/sda_req_if.sv
// ============================================================================
// sda_req_if: request channel of the signed decimal adder
// Carries one word pair of both operands plus signs and the final marker.
// ============================================================================
`default_nettype none

interface sda_req_if;
   logic                        valid;
   logic                        ready;
   logic [sda_pkg::WORD_W-1:0]  a_word;
   logic [sda_pkg::WORD_W-1:0]  b_word;
   logic                        a_negative;
   logic                        b_negative;
   logic                        final_word;

   modport source (output valid, a_word, b_word, a_negative, b_negative, final_word,
                   input ready);
   modport sink   (input valid, a_word, b_word, a_negative, b_negative, final_word,
                   output ready);
endinterface

`default_nettype wire

>>> hdl/sda_rsp_if.sv
// ============================================================================
// sda_rsp_if: response channel of the signed decimal adder
// Carries one packed BCD result word with sign, digit count and last marker.
// ============================================================================
`default_nettype none

interface sda_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sda_pkg::WORD_W-1:0]  sum_word;
   logic                        result_negative;
   logic [sda_pkg::COUNT_W-1:0] digit_count;
   logic                        last_word;

   modport source (output valid, sum_word, result_negative, digit_count, last_word,
                   input ready);
   modport sink   (input valid, sum_word, result_negative, digit_count, last_word,
                   output ready);
endinterface

`default_nettype wire

>>> hdl/sda_ctrl.sv
// ============================================================================
// sda_ctrl: sequencer of the signed decimal adder
// Loads word pairs, then steps the compare, add or subtract, carry and output
// passes over the stored words by issuing commands to the datapath.
// ============================================================================
`default_nettype none

module sda_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_final,
   output logic                      req_ready,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic                      rsp_last,
   input  wire sda_pkg::status_type  status,
   output sda_pkg::cmd_type          cmd
);

   typedef enum logic [8:0] {
      ST_LOAD      = 9'b000000001,
      ST_START     = 9'b000000010,
      ST_CMP_RD    = 9'b000000100,
      ST_CMP_OP    = 9'b000001000,
      ST_ADD_RD    = 9'b000010000,
      ST_ADD_OP    = 9'b000100000,
      ST_TOP       = 9'b001000000,
      ST_EMIT_RD   = 9'b010000000,
      ST_EMIT_WAIT = 9'b100000000
   } state_type;

   localparam logic [sda_pkg::CNT_W-1:0] FULL = sda_pkg::CNT_W'(sda_pkg::WORDS);
   localparam logic [sda_pkg::CNT_W-1:0] ONE  = sda_pkg::CNT_W'(1);

   state_type                    state_ff, state_in;
   logic [sda_pkg::CNT_W-1:0]    load_cnt_ff, load_cnt_in;
   logic [sda_pkg::CNT_W-1:0]    words_ff, words_in;
   logic [sda_pkg::CNT_W-1:0]    idx_ff, idx_in;
   logic                         full;
   logic                         accept;

   assign full   = (load_cnt_ff == FULL);
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      words_in    = words_ff;
      idx_in      = idx_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      rsp_last    = 1'b0;
      cmd         = '0;
      cmd.addr    = idx_ff;

      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.addr  = load_cnt_ff;
            if (accept) begin
               cmd.store_wr = !full;
               load_cnt_in  = full ? load_cnt_ff : load_cnt_ff + ONE;
               if (req_final) begin
                  cmd.cap_signs = 1'b1;
                  cmd.clear_run = 1'b1;
                  words_in      = load_cnt_in;
                  load_cnt_in   = '0;
                  state_in      = ST_START;
               end
            end
         end
         ST_START: begin
            if (status.signs_differ) begin
               idx_in   = words_ff - ONE;
               state_in = ST_CMP_RD;
            end else begin
               idx_in   = '0;
               state_in = ST_ADD_RD;
            end
         end
         ST_CMP_RD: begin
            cmd.op_rd = 1'b1;
            state_in  = ST_CMP_OP;
         end
         ST_CMP_OP: begin
            cmd.cmp_eval = 1'b1;
            if (status.words_differ || idx_ff == '0) begin
               idx_in   = '0;
               state_in = ST_ADD_RD;
            end else begin
               idx_in   = idx_ff - ONE;
               state_in = ST_CMP_RD;
            end
         end
         ST_ADD_RD: begin
            cmd.op_rd = 1'b1;
            state_in  = ST_ADD_OP;
         end
         ST_ADD_OP: begin
            cmd.arith_eval = 1'b1;
            idx_in         = idx_ff + ONE;
            state_in       = (idx_ff + ONE == words_ff) ? ST_TOP : ST_ADD_RD;
         end
         ST_TOP: begin
            cmd.top_eval = 1'b1;
            idx_in       = '0;
            state_in     = ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            cmd.res_rd = 1'b1;
            state_in   = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            rsp_valid = 1'b1;
            rsp_last  = (idx_ff == status.last_idx);
            if (rsp_ready) begin
               if (rsp_last) begin
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + ONE;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         load_cnt_ff <= '0;
         words_ff    <= '0;
         idx_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         words_ff    <= words_in;
         idx_ff      <= idx_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/sda_dpath.sv
// ============================================================================
// sda_dpath: datapath of the signed decimal adder
// Operand and result memories, one-word BCD add and subtract with a lookahead
// carry, word compare, leading-digit tracking and the response payload.
// ============================================================================
`default_nettype none

module sda_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sda_pkg::cmd_type              cmd,
   output sda_pkg::status_type                status,
   input  wire logic [sda_pkg::WORD_W-1:0]    a_word,
   input  wire logic [sda_pkg::WORD_W-1:0]    b_word,
   input  wire logic                          a_negative,
   input  wire logic                          b_negative,
   output logic [sda_pkg::WORD_W-1:0]         sum_word,
   output logic                               result_negative,
   output logic [sda_pkg::COUNT_W-1:0]        digit_count
);

   localparam int DPW = sda_pkg::DIGITS_PER_WORD;

   // Memories.
   logic [sda_pkg::WORD_W-1:0] store_a_ff [sda_pkg::WORDS];
   logic [sda_pkg::WORD_W-1:0] store_b_ff [sda_pkg::WORDS];
   logic [sda_pkg::WORD_W-1:0] result_ff  [sda_pkg::WORDS + 1];
   logic [sda_pkg::WORD_W-1:0] a_rd_ff, b_rd_ff, res_rd_ff;

   // Run state.
   logic                         sign_a_ff, sign_a_in;
   logic                         sign_b_ff, sign_b_in;
   logic                         carry_ff, carry_in;
   logic                         a_big_ff, a_big_in;
   logic                         hi_valid_ff, hi_valid_in;
   logic [sda_pkg::CNT_W-1:0]    hi_word_ff, hi_word_in;
   logic [sda_pkg::DIG_AW-1:0]   hi_digit_ff, hi_digit_in;

   // Word arithmetic.
   logic [sda_pkg::WORD_W-1:0]   ca, cb, big_w, small_w, word_out, top_word;
   logic [DPW-1:0]               gen, prop;
   logic [DPW:0]                 xv, cv, cin_v;
   logic [3:0]                   dx, dy;
   logic [4:0]                   t;
   logic [sda_pkg::DIG_AW-1:0]   lead;
   logic                         add_mode;
   logic [sda_pkg::WORD_AW-1:0]  op_addr;

   assign add_mode = (sign_a_ff == sign_b_ff);
   assign op_addr  = cmd.addr[sda_pkg::WORD_AW-1:0];

   always_comb begin
      ca      = sda_pkg::clamp_word(a_rd_ff);
      cb      = sda_pkg::clamp_word(b_rd_ff);
      big_w   = a_big_ff ? ca : cb;
      small_w = a_big_ff ? cb : ca;
      gen     = '0;
      prop    = '0;
      dx      = '0;
      dy      = '0;
      t       = '0;
      // Per-digit generate and propagate of the decimal carry or borrow.
      for (int k = 0; k < DPW; k++) begin
         dx = big_w[4*k +: 4];
         dy = small_w[4*k +: 4];
         if (add_mode) begin
            t       = {1'b0, dx} + {1'b0, dy};
            gen[k]  = (t > {1'b0, sda_pkg::DIGIT_MAX});
            prop[k] = (t == {1'b0, sda_pkg::DIGIT_MAX});
         end else begin
            gen[k]  = (dx < dy);
            prop[k] = (dx == dy);
         end
      end
      // The digit chain resolves as a binary add of the generate vector onto
      // the generate-or-propagate vector; the carry into each digit falls out
      // of the sum bits.
      xv    = {1'b0, gen | prop};
      cv    = xv + {1'b0, gen} + (DPW + 1)'(carry_ff);
      cin_v = cv ^ xv ^ {1'b0, gen};
      word_out = '0;
      lead     = '0;
      for (int k = 0; k < DPW; k++) begin
         dx = big_w[4*k +: 4];
         dy = small_w[4*k +: 4];
         if (add_mode) begin
            t = {1'b0, dx} + {1'b0, dy} + 5'(cin_v[k]);
            if (cin_v[k+1]) begin
               t = t - sda_pkg::RADIX;
            end
         end else begin
            t = {1'b0, dx} - {1'b0, dy} - 5'(cin_v[k]);
            if (cin_v[k+1]) begin
               t = t + sda_pkg::RADIX;
            end
         end
         word_out[4*k +: 4] = t[3:0];
         if (t[3:0] != 4'd0) begin
            lead = sda_pkg::DIG_AW'(k);
         end
      end
      top_word = sda_pkg::WORD_W'(add_mode & carry_ff);
   end

   always_comb begin
      sign_a_in   = sign_a_ff;
      sign_b_in   = sign_b_ff;
      carry_in    = carry_ff;
      a_big_in    = a_big_ff;
      hi_valid_in = hi_valid_ff;
      hi_word_in  = hi_word_ff;
      hi_digit_in = hi_digit_ff;
      if (cmd.cap_signs) begin
         sign_a_in = a_negative;
         sign_b_in = b_negative;
      end
      if (cmd.clear_run) begin
         carry_in    = 1'b0;
         a_big_in    = 1'b1;
         hi_valid_in = 1'b0;
         hi_word_in  = '0;
         hi_digit_in = '0;
      end
      if (cmd.cmp_eval) begin
         a_big_in = (ca >= cb);
      end
      if (cmd.arith_eval) begin
         carry_in = cin_v[DPW];
         if (word_out != '0) begin
            hi_valid_in = 1'b1;
            hi_word_in  = cmd.addr;
            hi_digit_in = lead;
         end
      end
      if (cmd.top_eval && top_word != '0) begin
         hi_valid_in = 1'b1;
         hi_word_in  = cmd.addr;
         hi_digit_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sign_a_ff   <= 1'b0;
         sign_b_ff   <= 1'b0;
         carry_ff    <= 1'b0;
         a_big_ff    <= 1'b1;
         hi_valid_ff <= 1'b0;
         hi_word_ff  <= '0;
         hi_digit_ff <= '0;
      end else begin
         sign_a_ff   <= sign_a_in;
         sign_b_ff   <= sign_b_in;
         carry_ff    <= carry_in;
         a_big_ff    <= a_big_in;
         hi_valid_ff <= hi_valid_in;
         hi_word_ff  <= hi_word_in;
         hi_digit_ff <= hi_digit_in;
      end
   end

   // Operand stores: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.store_wr) begin
         store_a_ff[op_addr] <= a_word;
         store_b_ff[op_addr] <= b_word;
      end
      if (cmd.op_rd) begin
         a_rd_ff <= store_a_ff[op_addr];
         b_rd_ff <= store_b_ff[op_addr];
      end
   end

   // Result store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.arith_eval) begin
         result_ff[cmd.addr] <= word_out;
      end else if (cmd.top_eval) begin
         result_ff[cmd.addr] <= top_word;
      end
      if (cmd.res_rd) begin
         res_rd_ff <= result_ff[cmd.addr];
      end
   end

   assign status.signs_differ = !add_mode;
   assign status.words_differ = (ca != cb);
   assign status.last_idx     = hi_valid_ff ? hi_word_ff : '0;

   assign sum_word        = res_rd_ff;
   assign result_negative = hi_valid_ff &&
                            (add_mode ? sign_a_ff : (a_big_ff ? sign_a_ff : sign_b_ff));
   assign digit_count     = hi_valid_ff ?
                            (sda_pkg::COUNT_W'(hi_word_ff) * sda_pkg::COUNT_W'(DPW)
                             + sda_pkg::COUNT_W'(hi_digit_ff) + sda_pkg::COUNT_W'(1))
                            : sda_pkg::COUNT_W'(1);

endmodule

`default_nettype wire

>>> hdl/signed_decimal_adder_top.sv
// ============================================================================
// signed_decimal_adder_top: signed-magnitude packed BCD adder
// Sequence: request word pairs are stored as they are taken. After the final
// request, a start step, a compare pass from the top word down when signs differ,
// an add or subtract pass over the stored word pairs and a carry word store
// follow; each response word is then read from the result store and handed off.
// Throughput: one run at a time; the operand store read port sets the pace.
// Reset is synchronous and active high; it returns the block to loading.
// ============================================================================
`default_nettype none

module signed_decimal_adder_top (
   input  wire logic  clock,
   input  wire logic  reset,
   sda_req_if.sink    req_chan,
   sda_rsp_if.source  rsp_chan
);

   // The controller sequences the passes; the datapath holds the words and
   // does the per-word arithmetic. They share only commands and status.
   sda_pkg::cmd_type    cmd;
   sda_pkg::status_type status;
   logic                req_ready;
   logic                rsp_valid;
   logic                rsp_last;

   sda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_final (req_chan.final_word),
      .req_ready (req_ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_last  (rsp_last),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath drives the response payload straight from its result read
   // register and run state, which hold still while a response waits.
   sda_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .a_word          (req_chan.a_word),
      .b_word          (req_chan.b_word),
      .a_negative      (req_chan.a_negative),
      .b_negative      (req_chan.b_negative),
      .sum_word        (rsp_chan.sum_word),
      .result_negative (rsp_chan.result_negative),
      .digit_count     (rsp_chan.digit_count)
   );

   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid     = rsp_valid;
   assign rsp_chan.last_word = rsp_last;

   // Loading and responding never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request and response active together");

   // A final request closes loading until the run has been sent.
   a_final_closes: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.final_word |=> !req_chan.ready)
      else $error("request accepted right after a final request");

   // Handing off the last response word reopens loading.
   a_last_reopens: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.last_word |=> req_chan.ready)
      else $error("loading not reopened after last response");

   // A zero result is sent as positive.
   a_zero_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.last_word && rsp_chan.digit_count == 9'd1
      && rsp_chan.sum_word == 64'd0 |-> !rsp_chan.result_negative)
      else $error("zero result marked negative");

endmodule

`default_nettype wire

>>> bench/tb_signed_decimal_adder_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_signed_decimal_adder_top: self-checking bench for the signed BCD adder
// Sends runs of packed BCD word pairs, predicts every result word from its own
// copy of the operand stores, and compares each response field by field.
// Directed runs cover the widest carry, signed zero, borrow chains and
// non-decimal digits. Random runs vary length, shape and signs. Random idle
// bursts on both channels give way to a tail with no idling.
// ============================================================================

module tb_signed_decimal_adder_top;

   // Digit buffer size: every stored digit plus room for the final carry digit.
   localparam int DIGIT_SLOTS  = (sda_pkg::WORDS + 1) * sda_pkg::DIGITS_PER_WORD;
   localparam int DIGIT_LIMIT  = 9;
   localparam int DECIMAL_BASE = 10;
   // Largest run the bench sends. Words past WORDS are dropped by the block.
   localparam int RUN_MAX      = sda_pkg::WORDS + 3;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 200;
   localparam int REPORT_LINES = 40;
   localparam logic [sda_pkg::WORD_W-1:0] ALL_NINES = {(sda_pkg::WORD_W / 4){4'h9}};

   // One expected response word.
   typedef struct packed {
      logic [sda_pkg::WORD_W-1:0]  sum_word;
      logic                        result_negative;
      logic [sda_pkg::COUNT_W-1:0] digit_count;
      logic                        last_word;
   } bcd_sum_type;

   logic clock;
   logic reset;

   sda_req_if req_chan ();
   sda_rsp_if rsp_chan ();

   signed_decimal_adder_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state: a private copy of what the block should hold.
   logic [sda_pkg::WORD_W-1:0] a_store [sda_pkg::WORDS];
   logic [sda_pkg::WORD_W-1:0] b_store [sda_pkg::WORDS];
   int                         words_held;

   // Result words that are predicted but not yet seen on the response channel.
   bcd_sum_type pending_sums [$];

   // Operand words for the next run, filled by the tests before sending.
   logic [sda_pkg::WORD_W-1:0] run_a [RUN_MAX];
   logic [sda_pkg::WORD_W-1:0] run_b [RUN_MAX];

   int mismatch_count;
   int cycle_count;
   int stall_left;
   int response_index;
   bit idle_on;

   always #5 clock = ~clock;

   // A cycle counter ends a run that hangs: a lost response or a stuck ready.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // The response side holds ready high, except for random stall bursts while
   // idling is enabled.
   always @(posedge clock) begin
      if (stall_left != 0)
         stall_left--;
      else if (idle_on && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 12);
      rsp_chan.ready <= (stall_left == 0);
   end

   // Prints one line per mismatch (up to a cap) and counts every one of them.
   task automatic report_mismatch(input string what,
                                  input logic [sda_pkg::WORD_W-1:0] got,
                                  input logic [sda_pkg::WORD_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES)
         $display("[%0t] ERROR response %0d, %s: got %h, want %h",
                  $time, response_index, what, got, want);
   endtask

   // Predicts the block for one accepted request. A word pair is stored while
   // there is room; a final request computes the signed sum over the stored
   // words and queues its result words, least significant first.
   function automatic void compute_decimal_sum(input logic [sda_pkg::WORD_W-1:0] a_word,
                                               input logic [sda_pkg::WORD_W-1:0] b_word,
                                               input logic a_neg, input logic b_neg,
                                               input logic is_final);
      int da [DIGIT_SLOTS];
      int db [DIGIT_SLOTS];
      int dr [DIGIT_SLOTS];
      int len, cmp, count, nwords, carry, borrow, s, hi, lo, nib;
      logic neg;
      bcd_sum_type item;

      if (words_held < sda_pkg::WORDS) begin
         a_store[words_held] = a_word;
         b_store[words_held] = b_word;
         words_held++;
      end
      if (!is_final)
         return;

      len = words_held * sda_pkg::DIGITS_PER_WORD;
      for (int i = 0; i < DIGIT_SLOTS; i++) begin
         da[i] = 0;
         db[i] = 0;
         dr[i] = 0;
      end
      // Digits above nine count as nine.
      for (int i = 0; i < words_held; i++) begin
         for (int k = 0; k < sda_pkg::DIGITS_PER_WORD; k++) begin
            nib = int'(a_store[i][4*k +: 4]);
            da[i*sda_pkg::DIGITS_PER_WORD + k] = (nib > DIGIT_LIMIT) ? DIGIT_LIMIT : nib;
            nib = int'(b_store[i][4*k +: 4]);
            db[i*sda_pkg::DIGITS_PER_WORD + k] = (nib > DIGIT_LIMIT) ? DIGIT_LIMIT : nib;
         end
      end

      if (a_neg == b_neg) begin
         carry = 0;
         for (int i = 0; i < len; i++) begin
            s = da[i] + db[i] + carry;
            carry = (s > DIGIT_LIMIT) ? 1 : 0;
            dr[i] = carry ? s - DECIMAL_BASE : s;
         end
         dr[len] = carry;
         neg = a_neg;
      end else begin
         // Compare magnitudes from the top digit down, then subtract the
         // smaller from the larger.
         cmp = 0;
         for (int i = len - 1; i >= 0 && cmp == 0; i--) begin
            if (da[i] > db[i])
               cmp = 1;
            else if (da[i] < db[i])
               cmp = -1;
         end
         borrow = 0;
         for (int i = 0; i < len; i++) begin
            hi = (cmp >= 0) ? da[i] : db[i];
            lo = ((cmp >= 0) ? db[i] : da[i]) + borrow;
            if (hi < lo) begin
               dr[i] = hi + DECIMAL_BASE - lo;
               borrow = 1;
            end else begin
               dr[i] = hi - lo;
               borrow = 0;
            end
         end
         neg = (cmp >= 0) ? a_neg : b_neg;
         if (cmp == 0)
            neg = 1'b0;
      end

      count = 1;
      for (int i = len; i >= 0; i--) begin
         if (dr[i] != 0) begin
            count = i + 1;
            break;
         end
      end
      // Zero is always positive.
      if (count == 1 && dr[0] == 0)
         neg = 1'b0;

      nwords = (count + sda_pkg::DIGITS_PER_WORD - 1) / sda_pkg::DIGITS_PER_WORD;
      for (int i = 0; i < nwords; i++) begin
         item.sum_word = '0;
         for (int k = 0; k < sda_pkg::DIGITS_PER_WORD; k++)
            item.sum_word[4*k +: 4] = 4'(dr[i*sda_pkg::DIGITS_PER_WORD + k]);
         item.result_negative = neg;
         item.digit_count     = sda_pkg::COUNT_W'(count);
         item.last_word       = (i == nwords - 1);
         pending_sums.push_back(item);
      end
      words_held = 0;
   endfunction

   // Monitor: both channels are sampled at the rising edge, before any
   // nonblocking update of that edge, so they see exactly what the block saw.
   // Each response is checked against the oldest prediction, and each
   // accepted request feeds the predictor.
   always @(posedge clock) begin
      bcd_sum_type want;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_sums.size() == 0) begin
               report_mismatch("response with no result expected",
                               rsp_chan.sum_word, '0);
            end else begin
               want = pending_sums.pop_front();
               if (rsp_chan.sum_word !== want.sum_word)
                  report_mismatch("sum_word", rsp_chan.sum_word, want.sum_word);
               if (rsp_chan.result_negative !== want.result_negative)
                  report_mismatch("result_negative",
                                  sda_pkg::WORD_W'(rsp_chan.result_negative),
                                  sda_pkg::WORD_W'(want.result_negative));
               if (rsp_chan.digit_count !== want.digit_count)
                  report_mismatch("digit_count",
                                  sda_pkg::WORD_W'(rsp_chan.digit_count),
                                  sda_pkg::WORD_W'(want.digit_count));
               if (rsp_chan.last_word !== want.last_word)
                  report_mismatch("last_word", sda_pkg::WORD_W'(rsp_chan.last_word),
                                  sda_pkg::WORD_W'(want.last_word));
            end
            response_index++;
         end
         if (req_chan.valid && req_chan.ready)
            compute_decimal_sum(req_chan.a_word, req_chan.b_word,
                                req_chan.a_negative, req_chan.b_negative,
                                req_chan.final_word);
      end
   end

   function automatic logic [sda_pkg::WORD_W-1:0] random_bcd_word();
      logic [sda_pkg::WORD_W-1:0] w;
      for (int k = 0; k < sda_pkg::WORD_W / 4; k++)
         w[4*k +: 4] = 4'($urandom_range(0, DIGIT_LIMIT));
      return w;
   endfunction

   // Sends one request and returns at the edge that accepts it. Valid stays
   // high afterwards, so back-to-back requests need a single assignment.
   task automatic send_pair(input logic [sda_pkg::WORD_W-1:0] a_word,
                            input logic [sda_pkg::WORD_W-1:0] b_word,
                            input logic a_neg, input logic b_neg, input logic is_final);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.a_word     <= a_word;
      req_chan.b_word     <= b_word;
      req_chan.a_negative <= a_neg;
      req_chan.b_negative <= b_neg;
      req_chan.final_word <= is_final;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   // Sends the first n word pairs of the run buffers. Signs matter only on the
   // final request; earlier requests carry random sign bits.
   task automatic send_run(input int n, input logic a_neg, input logic b_neg);
      for (int i = 0; i < n; i++) begin
         if (i == n - 1)
            send_pair(run_a[i], run_b[i], a_neg, b_neg, 1'b1);
         else
            send_pair(run_a[i], run_b[i], 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0);
      end
   endtask

   // Lowers valid and waits until every predicted result word has arrived.
   // The first edge lets the monitor record the request accepted just before.
   task automatic wait_for_sums_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_sums.size() != 0)
         @(posedge clock);
   endtask

   // Widest operands: all nines on both sides, both negative. The carry runs
   // through every digit and gives the largest result of 257 digits.
   task automatic test_widest_operands();
      for (int i = 0; i < sda_pkg::WORDS; i++) begin
         run_a[i] = ALL_NINES;
         run_b[i] = ALL_NINES;
      end
      send_run(sda_pkg::WORDS, 1'b1, 1'b1);
   endtask

   // Short runs after the widest one, so stale store words above the loaded
   // ones must read as zero: zero sums, carry out of one word, equal and
   // nearly equal magnitudes, a borrow across a word, and non-decimal digits.
   task automatic test_sign_and_zero_cases();
      // Positive zero plus positive zero.
      run_a[0] = '0;
      run_b[0] = '0;
      send_run(1, 1'b0, 1'b0);
      // Negative zero plus negative zero gives a positive zero.
      send_run(1, 1'b1, 1'b1);
      // A word of nines plus one carries into a second result word.
      run_a[0] = ALL_NINES;
      run_b[0] = 64'd1;
      send_run(1, 1'b0, 1'b0);
      // Equal magnitudes with different signs cancel to a positive zero.
      run_a[0] = 64'h0123_4567_8901_2345;
      run_a[1] = 64'h9876_5432_1098_7654;
      run_b[0] = run_a[0];
      run_b[1] = run_a[1];
      send_run(2, 1'b1, 1'b0);
      // Magnitudes that differ only in the lowest digit; the negative second
      // operand is larger, so the result is negative one.
      run_b[0] = 64'h0123_4567_8901_2346;
      send_run(2, 1'b0, 1'b1);
      // One digit in the second word minus one borrows through a full word.
      run_a[0] = '0;
      run_a[1] = 64'd1;
      run_b[0] = 64'd1;
      run_b[1] = '0;
      send_run(2, 1'b0, 1'b1);
      // Every nibble above nine is read as nine; all bits of a_word are set.
      run_a[0] = '1;
      run_b[0] = 64'd1;
      send_run(1, 1'b0, 1'b1);
   endtask

   // Random runs of about the given number of requests. Most runs are short;
   // a few fill the stores, and some overflow them so that the extra words and
   // even the final word are dropped. Shapes mix random digits with noise,
   // equal or nearly equal magnitudes, long carry and borrow chains, and
   // leading zero words that shorten the result.
   task automatic test_random_runs(input int items, input bit force_overflow);
      int sent, n, pick, shape, j, k, top;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(0, 99);
         if (force_overflow && sent == 0)
            n = $urandom_range(sda_pkg::WORDS + 1, RUN_MAX);
         else if (pick < 75)
            n = $urandom_range(1, 3);
         else if (pick < 90)
            n = $urandom_range(4, 8);
         else if (pick < 97)
            n = $urandom_range(9, sda_pkg::WORDS);
         else
            n = $urandom_range(sda_pkg::WORDS + 1, RUN_MAX);

         for (int i = 0; i < n; i++) begin
            run_a[i] = random_bcd_word();
            run_b[i] = random_bcd_word();
         end
         shape = $urandom_range(0, 99);
         if (shape < 10) begin
            // Raw noise: most words hold nibbles above nine.
            for (int i = 0; i < n; i++) begin
               run_a[i] = {$urandom, $urandom};
               run_b[i] = {$urandom, $urandom};
            end
         end else if (shape < 25) begin
            for (int i = 0; i < n; i++)
               run_b[i] = run_a[i];
         end else if (shape < 35) begin
            // Same magnitude except one digit somewhere.
            for (int i = 0; i < n; i++)
               run_b[i] = run_a[i];
            j = $urandom_range(0, n - 1);
            k = $urandom_range(0, sda_pkg::DIGITS_PER_WORD - 1);
            run_b[j][4*k +: 4] = 4'($urandom_range(0, DIGIT_LIMIT));
         end else if (shape < 45) begin
            // Nines against a small number: long carry or borrow chains.
            for (int i = 0; i < n; i++) begin
               run_a[i] = ALL_NINES;
               run_b[i] = '0;
            end
            run_b[0] = sda_pkg::WORD_W'($urandom_range(0, 99));
         end else if (shape < 55) begin
            // A single high digit against a small number: long borrow chain when signs differ.
            for (int i = 0; i < n; i++) begin
               run_a[i] = '0;
               run_b[i] = '0;
            end
            run_a[n-1][4*(sda_pkg::DIGITS_PER_WORD-1) +: 4] =
               4'($urandom_range(1, DIGIT_LIMIT));
            run_b[0] = sda_pkg::WORD_W'($urandom_range(1, 99));
         end
         if ($urandom_range(0, 4) == 0) begin
            top = $urandom_range(0, n - 1);
            for (int i = top; i < n; i++) begin
               run_a[i] = '0;
               if ($urandom_range(0, 1) == 0)
                  run_b[i] = '0;
            end
         end
         send_run(n, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         sent += n;
      end
   endtask

   // The sender stops after each short run until every result word is back,
   // so the next run starts on an idle block.
   task automatic test_pause_until_drained();
      int n;
      for (int r = 0; r < 3; r++) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) begin
            run_a[i] = random_bcd_word();
            run_b[i] = random_bcd_word();
         end
         send_run(n, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         wait_for_sums_drained();
      end
   endtask

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      idle_on             = 1'b1;
      stall_left          = 0;
      mismatch_count      = 0;
      cycle_count         = 0;
      response_index      = 0;
      words_held          = 0;
      req_chan.valid      = 1'b0;
      req_chan.a_word     = '0;
      req_chan.b_word     = '0;
      req_chan.a_negative = 1'b0;
      req_chan.b_negative = 1'b0;
      req_chan.final_word = 1'b0;
      rsp_chan.ready      = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_widest_operands();
      test_sign_and_zero_cases();
      test_random_runs(130, 1'b1);
      test_pause_until_drained();
      test_random_runs(80, 1'b0);
      // The tail runs with both sides at full rate.
      idle_on = 1'b0;
      test_random_runs(35, 1'b0);

      wait_for_sums_drained();
      // Any stray response after the last expected one is still caught here.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
